// ===== src/lbr_pkg.sv =====
// Shared types and constants for the LED blink-code digit reader.
// Used by the register block, the sequencer and the top level; no dependencies.
`timescale 1ns / 1ps

package lbr_pkg;

  // Event kinds carried on the input channel.
  localparam logic [1:0] MODE_TRIGGER = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_POLL    = 2'd2;

  // Configuration port geometry: two registers at byte addresses 0 and 8, 64-bit data.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DIGIT_CODES = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ZERO_FLASH  = 4'h8;

  // Register reset values.
  localparam logic [63:0] DIGIT_CODES_RST = 64'hFFFF_F917_1A61_7052;
  localparam logic [7:0]  ZERO_FLASH_RST  = 8'd60;

  // Special codes in the digit string.
  localparam logic [3:0] CODE_PAUSE = 4'd10;
  localparam logic [3:0] CODE_END   = 4'd15;

  // One input beat.
  typedef struct packed {
    logic [1:0] mode;
    logic       key_held;
  } lbr_event_t;

  // One result beat.
  typedef struct packed {
    logic led_on;
    logic busy_res;
  } lbr_result_t;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [63:0] digit_codes;
    logic [7:0]  zero_flash_polls;
  } lbr_cfg_t;

endpackage

// ===== src/lbr_cfg_regs.sv =====
// Configuration registers of the blink-code reader behind an APB-style port.
// Depends on lbr_pkg for addresses, reset values and the configuration struct.
`timescale 1ns / 1ps

module lbr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lbr_pkg::CFG_DATA_W-1:0]  prdata,
  output lbr_pkg::lbr_cfg_t               cfg
);
  import lbr_pkg::*;

  logic [63:0] digit_codes_r;
  logic [7:0]  zero_flash_r;
  logic        wr_en;

  // A write lands in the access phase; the port never stalls.
  assign wr_en = psel && penable && pwrite;

  // Register file with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_codes_r <= DIGIT_CODES_RST;
      zero_flash_r  <= ZERO_FLASH_RST;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_DIGIT_CODES: digit_codes_r <= pwdata;
        ADDR_ZERO_FLASH:  zero_flash_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back decoder.
  always_comb begin
    unique case (paddr)
      ADDR_DIGIT_CODES: prdata = digit_codes_r;
      ADDR_ZERO_FLASH:  prdata = {56'd0, zero_flash_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.digit_codes      = digit_codes_r;
  assign cfg.zero_flash_polls = zero_flash_r;

endmodule

// ===== src/lbr_seq.sv =====
// Readout sequencer: phase, countdowns and string position, one event per step.
// Depends on lbr_pkg for event, result and configuration types.
`timescale 1ns / 1ps

module lbr_seq #(
  parameter int unsigned CODE_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  lbr_pkg::lbr_event_t  ev,
  input  lbr_pkg::lbr_cfg_t    cfg,
  output lbr_pkg::lbr_result_t res
);
  import lbr_pkg::*;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEAD    = 3'd1;
  localparam logic [2:0] PH_LOAD    = 3'd2;
  localparam logic [2:0] PH_SHOW    = 3'd3;
  localparam logic [2:0] PH_GAP     = 3'd4;
  localparam logic [2:0] PH_RELEASE = 3'd5;

  localparam logic [5:0] LEAD_TICKS  = 6'd15;
  localparam logic [5:0] LEAD_ON_MIN = 6'd6;
  localparam logic [5:0] GAP_TICKS   = 6'd10;
  localparam logic [5:0] PAUSE_TICKS = 6'd24;
  localparam logic [4:0] SLOTS       = 5'(CODE_SLOTS);

  logic [2:0] phase_r, phase_nxt;
  logic [5:0] tick_r, tick_nxt;
  logic [7:0] flash_r, flash_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] cur_code;
  logic [3:0] digit;
  logic [4:0] pos_inc;
  logic [3:0] pos_next_slot;
  logic       led;

  // Code under the current position and the wrapped next position.
  assign cur_code      = cfg.digit_codes[{pos_r, 2'b00} +: 4];
  assign digit         = (cur_code == CODE_END) ? 4'd0 : cur_code;
  assign pos_inc       = {1'b0, pos_r} + 5'd1;
  assign pos_next_slot = (pos_inc >= SLOTS) ? 4'd0 : pos_inc[3:0];

  // Next-state and LED logic for one event.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    flash_nxt = flash_r;
    pos_nxt   = pos_r;
    led       = 1'b0;
    case (ev.mode)
      MODE_TRIGGER: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_LEAD;
          tick_nxt  = LEAD_TICKS;
        end
      end
      MODE_TICK: begin
        if (tick_r != 6'd0) tick_nxt = tick_r - 6'd1;
      end
      MODE_POLL: begin
        unique case (phase_r)
          PH_LEAD: begin
            if (tick_r > LEAD_ON_MIN) begin
              led = 1'b1;
            end else if (tick_r == 6'd0) begin
              pos_nxt   = 4'd0;
              flash_nxt = 8'd0;
              phase_nxt = PH_LOAD;
            end
          end
          PH_LOAD: begin
            if (cur_code == CODE_PAUSE) begin
              phase_nxt = PH_GAP;
              tick_nxt  = PAUSE_TICKS;
            end else begin
              if (digit == 4'd0) flash_nxt = cfg.zero_flash_polls;
              else               tick_nxt  = {digit, 2'b00} - 6'd1;
              phase_nxt = PH_SHOW;
            end
            pos_nxt = pos_next_slot;
          end
          PH_SHOW: begin
            if (flash_r != 8'd0) begin
              flash_nxt = flash_r - 8'd1;
              led       = 1'b1;
            end else if (tick_r == 6'd0) begin
              if (cur_code == CODE_END) begin
                phase_nxt = PH_RELEASE;
              end else begin
                // The gap count itself sits in the LED-on half of its period.
                tick_nxt  = GAP_TICKS;
                phase_nxt = PH_GAP;
                led       = GAP_TICKS[1];
              end
            end else begin
              led = tick_r[1];
            end
          end
          PH_GAP: begin
            if (tick_r == 6'd0) phase_nxt = PH_LOAD;
          end
          PH_RELEASE: begin
            if (!ev.key_held) phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State registers advance once per event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 6'd0;
      flash_r <= 8'd0;
      pos_r   <= 4'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      flash_r <= flash_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign res.led_on   = led;
  assign res.busy_res = (phase_nxt != PH_IDLE);

endmodule

// ===== src/led_blink_code_digit_reader_core.sv =====
// Top level of the LED blink-code digit reader: input register, sequencer,
// result register and configuration port. Depends on lbr_pkg, lbr_cfg_regs, lbr_seq.
// An accepted input beat waits in the input register and moves into the result register on advance.
// Throughput: one beat per cycle while out_ready is high; the sequencer step is combinational.
// Reset (rst_n low, synchronous) empties both stages, puts the sequencer in idle
// and restores the register defaults. No clearing pass is needed.
`timescale 1ns / 1ps

module led_blink_code_digit_reader_core #(
  parameter int unsigned CODE_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic                            in_key_held,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_led_on,
  output logic                            out_busy_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lbr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lbr_pkg::*;

  logic        in_vld_r;
  lbr_event_t  ev_r;
  logic        out_vld_r;
  lbr_result_t res_r;
  lbr_result_t res_nxt;
  lbr_cfg_t    cfg;
  logic        advance;

  assign pready = 1'b1;

  // Configuration registers.
  lbr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The held beat moves on whenever the result register is free or being drained.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.mode     <= in_mode;
      ev_r.key_held <= in_key_held;
    end
  end

  // Sequencer steps on the beat leaving the input stage.
  lbr_seq #(
    .CODE_SLOTS (CODE_SLOTS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .ev      (ev_r),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_led_on   = res_r.led_on;
  assign out_busy_res = res_r.busy_res;

endmodule

// ===== src/lbr_checker.sv =====
// Port-level checks for the blink-code reader, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module lbr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_led_on,
  input logic out_busy_res,
  input logic pready
);

  // A lit LED is only ever reported while a readout is running.
  a_led_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_led_on || out_busy_res))
    else $error("LED on reported while idle");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_led_on) && $stable(out_busy_res)))
    else $error("result beat changed while stalled");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result register that fills from empty does so with a beat that passed straight
  // through the input register without waiting.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && $past(rst_n, 2)) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without an input beat");

  // The configuration port never stalls.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind led_blink_code_digit_reader_core lbr_checker u_lbr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_led_on   (out_led_on),
  .out_busy_res (out_busy_res),
  .pready       (pready)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the LED blink-code digit reader core.
// Drives event beats and APB register writes, predicts every result beat and checks it.
// Depends on lbr_pkg and led_blink_code_digit_reader_core.
`timescale 1ns / 1ps

module tb_top;
  import lbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Sequencer timing constants.
  localparam logic [5:0] LEAD_TICKS  = 6'd15;
  localparam logic [5:0] LEAD_DIM_AT = 6'd6;
  localparam logic [5:0] GAP_TICKS   = 6'd10;
  localparam logic [5:0] PAUSE_TICKS = 6'd24;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LEAD,
    SEQ_LOAD,
    SEQ_SHOW,
    SEQ_GAP,
    SEQ_RELEASE
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_TICK;
  logic in_key_held = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_led_on;
  logic out_busy_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = ADDR_DIGIT_CODES;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the registers and the sequencer state.
  logic [63:0] codes_copy = DIGIT_CODES_RST;
  logic [7:0]  zero_flash_copy = ZERO_FLASH_RST;
  seq_phase_t  seq_phase = SEQ_IDLE;
  logic [5:0]  tick_cnt = '0;
  logic [7:0]  flash_cnt = '0;
  logic [3:0]  code_pos = '0;

  lbr_event_t  event_queue[$];
  lbr_result_t predicted_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  led_blink_code_digit_reader_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_key_held  (in_key_held),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_led_on   (out_led_on),
    .out_busy_res (out_busy_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [3:0] code_at(input logic [3:0] pos);
    return codes_copy[4*pos +: 4];
  endfunction

  // One poll: advances the sequencer and returns the LED level.
  function automatic logic poll_sequencer(input logic key);
    logic led;
    logic [3:0] c;
    led = 1'b0;
    case (seq_phase)
      SEQ_LEAD: begin
        if (tick_cnt > LEAD_DIM_AT) begin
          led = 1'b1;
        end else if (tick_cnt == '0) begin
          code_pos = '0;
          flash_cnt = '0;
          seq_phase = SEQ_LOAD;
        end
      end
      SEQ_LOAD: begin
        c = code_at(code_pos);
        if (c == CODE_PAUSE) begin
          seq_phase = SEQ_GAP;
          tick_cnt = PAUSE_TICKS;
        end else begin
          // An end code loaded as a digit reads as zero.
          if (c == CODE_END) c = '0;
          if (c == '0) flash_cnt = zero_flash_copy;
          else tick_cnt = 6'({2'b00, c} * 4 - 1);
          seq_phase = SEQ_SHOW;
        end
        code_pos = code_pos + 4'd1;
      end
      SEQ_SHOW: begin
        if (flash_cnt != '0) begin
          flash_cnt = flash_cnt - 8'd1;
          led = 1'b1;
        end else begin
          if (tick_cnt == '0) begin
            if (code_at(code_pos) == CODE_END) begin
              seq_phase = SEQ_RELEASE;
            end else begin
              tick_cnt = GAP_TICKS;
              seq_phase = SEQ_GAP;
            end
          end
          // LED is on while the countdown mod 4 is 2 or 3.
          led = tick_cnt[1];
        end
      end
      SEQ_GAP: begin
        if (tick_cnt == '0) seq_phase = SEQ_LOAD;
      end
      SEQ_RELEASE: begin
        if (!key) seq_phase = SEQ_IDLE;
      end
      default: ;
    endcase
    return led;
  endfunction

  // Applies one event beat to the shadow state and returns the result beat it causes.
  function automatic lbr_result_t advance_sequencer(input lbr_event_t ev);
    lbr_result_t res;
    res.led_on = 1'b0;
    case (ev.mode)
      MODE_TRIGGER: begin
        if (seq_phase == SEQ_IDLE) begin
          seq_phase = SEQ_LEAD;
          tick_cnt = LEAD_TICKS;
        end
      end
      MODE_TICK: begin
        if (tick_cnt != '0) tick_cnt = tick_cnt - 6'd1;
      end
      MODE_POLL: res.led_on = poll_sequencer(ev.key_held);
      default: ;
    endcase
    res.busy_res = (seq_phase != SEQ_IDLE);
    return res;
  endfunction

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : event_driver
    lbr_event_t accepted;
    lbr_event_t next_ev;
    static int unsigned burst_left = 0;
    static int unsigned gap_left = 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted.mode = in_mode;
        accepted.key_held = in_key_held;
        predicted_results.push_back(advance_sequencer(accepted));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          next_ev = event_queue.pop_front();
          in_mode <= next_ev.mode;
          in_key_held <= next_ev.key_held;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each beat with the oldest prediction; ready follows
  // a rotating stall pattern that is replaced now and then.
  always @(posedge clk) begin : result_monitor
    lbr_result_t want;
    static logic [15:0] stall_pattern = '1;
    static int unsigned pattern_age = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result beat with nothing predicted");
        end else begin
          want = predicted_results.pop_front();
          if (out_led_on !== want.led_on)
            report_mismatch($sformatf("led_on %b, predicted %b", out_led_on, want.led_on));
          if (out_busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, predicted %b",
                                      out_busy_res, want.busy_res));
        end
      end
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
        pattern_age = $urandom_range(20, 80);
      end else begin
        pattern_age--;
      end
      out_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_event(input logic [1:0] mode, input logic key);
    lbr_event_t ev;
    ev.mode = mode;
    ev.key_held = key;
    event_queue.push_back(ev);
  endtask

  // Waits until every beat has gone through and the pipeline has emptied.
  task automatic settle();
    while (event_queue.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_DIGIT_CODES) codes_copy = data;
    else zero_flash_copy = data[7:0];
  endtask

  // Feeds readout traffic that follows the (slightly lagging) predicted phase, so
  // that most beats move the sequencer forward; a few are noise.
  task automatic feed_readout(input int unsigned n_items);
    lbr_event_t ev;
    int unsigned roll;
    for (int i = 0; i < n_items; i++) begin
      while (event_queue.size() >= 3) @(negedge clk);
      roll = $urandom_range(0, 99);
      ev.key_held = ($urandom_range(0, 3) != 0);
      ev.mode = MODE_POLL;
      if (roll < 5) begin
        ev.mode = 2'($urandom_range(0, 3));
      end else begin
        case (seq_phase)
          SEQ_IDLE: ev.mode = MODE_TRIGGER;
          SEQ_LEAD, SEQ_GAP: ev.mode = (roll < 70) ? MODE_TICK : MODE_POLL;
          SEQ_SHOW: begin
            if (flash_cnt == '0 && roll < 55) ev.mode = MODE_TICK;
          end
          SEQ_RELEASE: ev.key_held = (roll < 60);
          default: ;
        endcase
      end
      event_queue.push_back(ev);
    end
  endtask

  // Random string weighted toward short digits, pauses and end codes.
  function automatic logic [63:0] random_code_string();
    logic [63:0] s;
    int unsigned r;
    for (int i = 0; i < 16; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) s[4*i +: 4] = 4'($urandom_range(0, 3));
      else if (r < 60) s[4*i +: 4] = CODE_PAUSE;
      else if (r < 72) s[4*i +: 4] = CODE_END;
      else s[4*i +: 4] = 4'($urandom_range(0, 15));
    end
    return s;
  endfunction

  task automatic run_setting(input logic [63:0] codes, input logic [7:0] flash_polls,
                             input int unsigned n_items);
    settle();
    write_register(ADDR_DIGIT_CODES, codes);
    write_register(ADDR_ZERO_FLASH, {56'd0, flash_polls});
    feed_readout(n_items);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start on the reset defaults: idle events, unused mode, a tick at
    // zero, a trigger while busy, and the lead-in flash going dark at six.
    push_event(MODE_POLL, 1'b0);
    push_event(MODE_POLL, 1'b1);
    push_event(MODE_TICK, 1'b1);
    push_event(2'b11, 1'b1);
    push_event(2'b11, 1'b0);
    push_event(MODE_TRIGGER, 1'b0);
    push_event(MODE_TRIGGER, 1'b1);
    push_event(MODE_POLL, 1'b1);
    repeat (8) push_event(MODE_TICK, 1'b0);
    push_event(MODE_POLL, 1'b1);
    push_event(MODE_TICK, 1'b1);
    push_event(MODE_POLL, 1'b1);
    push_event(2'b11, 1'b1);
    feed_readout(50);

    // Random strings first, then the corner settings.
    repeat (4) begin
      run_setting(random_code_string(),
                  ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 6))
                                             : 8'($urandom_range(0, 255)),
                  60);
    end
    // Pause followed by an end code that is loaded as a digit.
    run_setting(64'hFFFF_FFFF_FFFF_FFFA, 8'd2, 60);
    // End code at the first position.
    run_setting(64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 40);
    // Digits above nine.
    run_setting(64'hFFFF_FFFF_FFFF_EDCB, 8'd1, 110);
    // No end code: the position wraps.
    run_setting(64'h1111_1111_1111_1111, 8'd5, 70);
    // All zero digits with no flash at all.
    run_setting(64'h0000_0000_0000_0000, 8'd0, 60);
    // Longest zero flash.
    run_setting(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 60);

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
